// ===== rtl/timer_slot_table_assert.svh =====
// Assertion macros used by the timer slot table checker.
`ifndef TIMER_SLOT_TABLE_ASSERT_SVH
`define TIMER_SLOT_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tst_pkg.sv =====
// Shared types and constants for the timer slot table.
package tst_pkg;

   localparam int SLOT_COUNT = 10;
   localparam int NOW_W      = 32;
   localparam int SECS_W     = 12;
   localparam int TAG_W      = 16;
   localparam int SLOT_W     = 4;

   localparam logic [NOW_W-1:0]  US_PER_SECOND     = 32'd1000000;
   localparam logic [SECS_W-1:0] MAX_DELAY_SECONDS = 12'd2147;

   typedef struct packed {
      logic [NOW_W-1:0] deadline;
      logic [TAG_W-1:0] tag;
   } slot_type;

   // Inactive deadline, owner tag of minus one.
   localparam slot_type SLOT_RESET = '{deadline: '0, tag: '1};

endpackage

// ===== rtl/tst_slot_mem.sv =====
// Slot storage: synchronous memory with one read and one write port, valid bits per entry.
module tst_slot_mem #(
   parameter int DEPTH = tst_pkg::SLOT_COUNT,
   parameter int AW    = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output tst_pkg::slot_type  rd_data,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  tst_pkg::slot_type  wr_data
);

   tst_pkg::slot_type mem_ff [DEPTH];
   tst_pkg::slot_type rd_data_ff;
   logic [DEPTH-1:0]  vld_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // Entries never written read back as the reset slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : tst_pkg::SLOT_RESET;

endmodule

// ===== rtl/timer_slot_table.sv =====
// Timer slot table top level: command port, slot scan sequencer and result register.
//
// Usage: drive req_func, req_now_us, req_delay_seconds and req_tag with start high;
// the command word is taken at a clock edge where start is high and busy is low.
// Add (func 0) rearms the slot owning a positive tag, else takes the first slot
// whose deadline is before now, and answers with exactly one result word (last=1).
// Tick (func 1) reports every active slot whose deadline has passed, in slot
// order, clearing its deadline; the final report carries last=1. A tick with
// nothing expired gives no result word.
// Each result word sits on the rsp_ ports for one cycle, marked by rsp_strobe;
// the receiver cannot stall, so there is no back-pressure on the result side.
// The slot memory is read one entry per cycle, and a command keeps busy high from
// acceptance through the scan of all SLOT_COUNT entries and the finish step; the add
// answer and the last tick report show up the cycle busy falls. A new command is
// taken only once busy has fallen, as the scan holds the single read port.
// Reset (synchronous, active high) deactivates every slot and sets its owner tag
// to minus one; no sweep is needed, a command can be issued right after reset.
module timer_slot_table #(
   parameter int SLOT_COUNT = tst_pkg::SLOT_COUNT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic        [tst_pkg::NOW_W-1:0]  req_now_us,
   input  logic        [tst_pkg::SECS_W-1:0] req_delay_seconds,
   input  logic signed [tst_pkg::TAG_W-1:0]  req_tag,
   output logic                              rsp_strobe,
   output logic                              rsp_kind,
   output logic                              rsp_found,
   output logic        [tst_pkg::SLOT_W-1:0] rsp_slot,
   output logic signed [tst_pkg::TAG_W-1:0]  rsp_fired_tag,
   output logic                              rsp_last
);

   localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SW = tst_pkg::SLOT_W;
   localparam int NW = tst_pkg::NOW_W;
   localparam logic [AW-1:0] LAST_IDX = AW'(SLOT_COUNT - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                  state_ff;
   logic                       func_ff;
   logic [NW-1:0]              now_ff;
   logic [NW-1:0]              delay_us_ff;
   logic [tst_pkg::TAG_W-1:0]  tag_ff;
   logic                       positive_ff;
   logic                       issue_ff;
   logic [AW-1:0]              rd_idx_ff;
   logic                       chk_vld_ff;
   logic [AW-1:0]              chk_idx_ff;
   logic                       match_hit_ff;
   logic [AW-1:0]              match_idx_ff;
   logic                       free_hit_ff;
   logic [AW-1:0]              free_idx_ff;
   logic                       pend_ff;
   logic [AW-1:0]              pend_slot_ff;
   logic [tst_pkg::TAG_W-1:0]  pend_tag_ff;
   logic                       rsp_strobe_ff;
   logic                       rsp_kind_ff;
   logic                       rsp_found_ff;
   logic [SW-1:0]              rsp_slot_ff;
   logic [tst_pkg::TAG_W-1:0]  rsp_tag_ff;
   logic                       rsp_last_ff;

   logic                       rd_en;
   tst_pkg::slot_type          entry;
   logic                       dl_before;
   logic                       tick_fire;
   logic                       tag_match;
   logic                       free_take;
   logic                       add_found;
   logic [AW-1:0]              add_pos;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   tst_pkg::slot_type          wr_data;
   logic [tst_pkg::SECS_W-1:0] secs_clamp;
   logic                       rsp_emit;

   assign busy = (state_ff != ST_IDLE);

   assign secs_clamp = (req_delay_seconds > tst_pkg::MAX_DELAY_SECONDS)
                       ? tst_pkg::MAX_DELAY_SECONDS : req_delay_seconds;

   assign rd_en     = (state_ff == ST_SCAN) && issue_ff;
   assign dl_before = entry.deadline < now_ff;
   assign tick_fire = chk_vld_ff && func_ff && (entry.deadline != '0) && dl_before;
   assign tag_match = chk_vld_ff && !func_ff && positive_ff && !match_hit_ff
                      && (entry.tag == tag_ff);
   assign free_take = chk_vld_ff && !func_ff && dl_before && !free_hit_ff;
   assign add_found = match_hit_ff || free_hit_ff;
   assign add_pos   = match_hit_ff ? match_idx_ff : free_idx_ff;

   // A word goes out on a held-back tick report or at the end of the scan.
   assign rsp_emit = ((state_ff == ST_SCAN) && tick_fire && pend_ff)
                     || ((state_ff == ST_FINISH) && (!func_ff || pend_ff));

   // Tick clears the deadline of the entry just read; add writes once the scan is over.
   assign wr_en   = tick_fire || ((state_ff == ST_FINISH) && !func_ff && add_found);
   assign wr_addr = tick_fire ? chk_idx_ff : add_pos;
   always_comb begin
      if (tick_fire) begin
         wr_data = '{deadline: '0, tag: entry.tag};
      end else begin
         wr_data = '{deadline: now_ff + delay_us_ff, tag: tag_ff};
      end
   end

   tst_slot_mem #(
      .DEPTH (SLOT_COUNT),
      .AW    (AW)
   ) u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (entry),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_ff      <= 1'b0;
         chk_vld_ff    <= 1'b0;
         match_hit_ff  <= 1'b0;
         free_hit_ff   <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_kind_ff   <= 1'b0;
         rsp_found_ff  <= 1'b0;
         rsp_slot_ff   <= '0;
         rsp_tag_ff    <= '0;
         rsp_last_ff   <= 1'b0;
      end else begin
         chk_vld_ff    <= rd_en;
         chk_idx_ff    <= rd_idx_ff;
         rsp_strobe_ff <= rsp_emit;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  func_ff      <= req_func;
                  now_ff       <= req_now_us;
                  delay_us_ff  <= NW'(secs_clamp) * tst_pkg::US_PER_SECOND;
                  tag_ff       <= req_tag;
                  positive_ff  <= !req_tag[tst_pkg::TAG_W-1] && (req_tag != '0);
                  rd_idx_ff    <= '0;
                  issue_ff     <= 1'b1;
                  match_hit_ff <= 1'b0;
                  free_hit_ff  <= 1'b0;
                  pend_ff      <= 1'b0;
                  state_ff     <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (issue_ff) begin
                  if (rd_idx_ff == LAST_IDX) begin
                     issue_ff <= 1'b0;
                  end else begin
                     rd_idx_ff <= rd_idx_ff + AW'(1);
                  end
               end
               if (tag_match) begin
                  match_hit_ff <= 1'b1;
                  match_idx_ff <= chk_idx_ff;
               end
               if (free_take) begin
                  free_hit_ff <= 1'b1;
                  free_idx_ff <= chk_idx_ff;
               end
               // Hold each report back one hit so the final one can carry last.
               if (tick_fire) begin
                  if (pend_ff) begin
                     rsp_kind_ff   <= 1'b1;
                     rsp_found_ff  <= 1'b0;
                     rsp_slot_ff   <= SW'(pend_slot_ff);
                     rsp_tag_ff    <= pend_tag_ff;
                     rsp_last_ff   <= 1'b0;
                  end
                  pend_ff      <= 1'b1;
                  pend_slot_ff <= chk_idx_ff;
                  pend_tag_ff  <= entry.tag;
               end
               if (chk_vld_ff && (chk_idx_ff == LAST_IDX)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!func_ff) begin
                  rsp_kind_ff   <= 1'b0;
                  rsp_found_ff  <= add_found;
                  rsp_slot_ff   <= add_found ? SW'(add_pos) : '0;
                  rsp_tag_ff    <= add_found ? tag_ff : '0;
                  rsp_last_ff   <= 1'b1;
               end else if (pend_ff) begin
                  rsp_kind_ff   <= 1'b1;
                  rsp_found_ff  <= 1'b0;
                  rsp_slot_ff   <= SW'(pend_slot_ff);
                  rsp_tag_ff    <= pend_tag_ff;
                  rsp_last_ff   <= 1'b1;
               end
               pend_ff  <= 1'b0;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_fired_tag = rsp_tag_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ===== rtl/tst_checker.sv =====
// Port-level checker for the timer slot table and its bind.
`include "timer_slot_table_assert.svh"

module tst_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_strobe,
   input logic                              rsp_kind,
   input logic                              rsp_found,
   input logic        [tst_pkg::SLOT_W-1:0] rsp_slot,
   input logic signed [tst_pkg::TAG_W-1:0]  rsp_fired_tag,
   input logic                              rsp_last
);

   `TST_ASSERT_NEXT(a_start_takes, start && !busy, busy, "accepted command did not raise busy")

   `TST_ASSERT_NOW(a_mid_word_busy, rsp_strobe && !rsp_last, busy, "non-final word outside a command")

   `TST_ASSERT_NOW(a_add_single, rsp_strobe && !rsp_kind, rsp_last, "add answer not marked last")

   `TST_ASSERT_NOW(a_fire_no_found, rsp_strobe && rsp_kind, !rsp_found, "fired report with found set")

   `TST_ASSERT_NOW(a_miss_zero, rsp_strobe && !rsp_kind && !rsp_found, (rsp_slot == '0) && (rsp_fired_tag == '0), "failed add with nonzero slot or tag")

endmodule

bind timer_slot_table tst_checker u_tst_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_kind      (rsp_kind),
   .rsp_found     (rsp_found),
   .rsp_slot      (rsp_slot),
   .rsp_fired_tag (rsp_fired_tag),
   .rsp_last      (rsp_last)
);
